[sv/dual_lifo_stack_engine_assert.svh]
`ifndef DUAL_LIFO_STACK_ENGINE_ASSERT_SVH
`define DUAL_LIFO_STACK_ENGINE_ASSERT_SVH

// Assertion helpers for the dual stack engine.
// They expect signals named clk and rst in the scope where they are used.

// A condition that must hold at every clock edge outside reset.
`define DLSE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define DLSE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define DLSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/dlse_pkg.sv]
package dlse_pkg;

  // Default sizes of the two stacks.
  localparam int DEPTH_DEFAULT     = 64;
  localparam int WORD_BITS_DEFAULT = 32;

  // Fixed field widths of the request and result beats.
  localparam int TYPE_BITS   = 3;
  localparam int DATA_BITS   = 32;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 7;

  // Request codes.
  localparam logic [TYPE_BITS-1:0] OP_PUSH     = 3'd0;
  localparam logic [TYPE_BITS-1:0] OP_POP      = 3'd1;
  localparam logic [TYPE_BITS-1:0] OP_REVERSE  = 3'd2;
  localparam logic [TYPE_BITS-1:0] OP_TRANSFER = 3'd3;
  localparam logic [TYPE_BITS-1:0] OP_COMPARE  = 3'd4;

  // Status codes.
  localparam logic [STATUS_BITS-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_EMPTY   = 2'd2;
  localparam logic [STATUS_BITS-1:0] STAT_REFUSED = 2'd3;

  typedef struct packed {
    logic [TYPE_BITS-1:0] req_type;
    logic                 stack_sel;
    logic [DATA_BITS-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [DATA_BITS-1:0]   pop_value;
    logic                   sel_empty;
    logic                   stacks_equal;
    logic                   a_more_than_b;
    logic [COUNT_BITS-1:0]  count_a;
    logic [COUNT_BITS-1:0]  count_b;
  } res_t;

endpackage

[sv/dlse_ram.sv]
module dlse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; a read of the address
  // being written returns the old word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/dual_lifo_stack_engine.sv]
// One request is worked at a time; a reverse swaps floor(n/2) entry pairs, a transfer moves
// all n words unless refused, and a compare reads word pairs while the stacks still match.
// The walks are set by the single registered read port of each stack memory. A new request
// is taken while the previous result beat waits.
// Reset is synchronous and clears both counts and all control state; memory contents are
// not cleared, since only entries below a count are ever used.
module dual_lifo_stack_engine import dlse_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_EXEC  = 10'b00_0000_0010,
    ST_POP   = 10'b00_0000_0100,
    ST_REV_A = 10'b00_0000_1000,
    ST_REV_B = 10'b00_0001_0000,
    ST_REV_C = 10'b00_0010_0000,
    ST_REV_D = 10'b00_0100_0000,
    ST_XFER  = 10'b00_1000_0000,
    ST_CMP   = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  req_t                   cur;
  logic [CW-1:0]          fill_a, fill_b;
  logic [CW-1:0]          sfill, dfill;
  logic [AW-1:0]          lo, hi;
  logic [CW-1:0]          idx;
  logic                   pend;
  logic [WORD_BITS-1:0]   tmp, pop_word;
  logic [STATUS_BITS-1:0] status_r;
  logic                   eq_r, more_r;
  logic                   xfer_rd, xfer_fits, cmp_rd, res_free;
  logic [CW:0]            xfer_total;

  // Memory ports seen from the selected (source) and the other stack.
  logic                 src_wr_en, dst_wr_en;
  logic [AW-1:0]        src_wr_addr, dst_wr_addr, src_rd_addr, dst_rd_addr;
  logic [WORD_BITS-1:0] src_wr_data, dst_wr_data, src_rd_data;
  logic                 a_wr_en, b_wr_en;
  logic [AW-1:0]        a_wr_addr, b_wr_addr, a_rd_addr, b_rd_addr;
  logic [WORD_BITS-1:0] a_wr_data, b_wr_data, a_rd_data, b_rd_data;

  // Selected and other stack counts, and the step conditions of the walks.
  assign sfill      = cur.stack_sel ? fill_b : fill_a;
  assign dfill      = cur.stack_sel ? fill_a : fill_b;
  assign xfer_rd    = (sfill != '0);
  assign xfer_fits  = ({1'b0, sfill} + {1'b0, dfill}) <= (CW + 1)'(DEPTH);
  assign cmp_rd     = eq_r && (idx < fill_a);
  assign res_free   = !res_valid || !res_stall;
  assign xfer_total = {1'b0, fill_a} + {1'b0, fill_b} + (CW + 1)'(pend);
  assign req_stall  = (state != ST_IDLE);

  // Memory accesses for each step.
  always_comb begin
    src_wr_en   = 1'b0;
    dst_wr_en   = 1'b0;
    src_wr_addr = '0;
    dst_wr_addr = '0;
    src_wr_data = '0;
    dst_wr_data = '0;
    src_rd_addr = '0;
    dst_rd_addr = '0;
    unique case (state)
      ST_EXEC: begin
        if (cur.req_type == OP_PUSH) begin
          src_wr_en   = sfill < CW'(DEPTH);
          src_wr_addr = AW'(sfill);
          src_wr_data = WORD_BITS'(cur.push_value);
        end
        src_rd_addr = AW'(sfill - 1'b1);
      end
      ST_REV_A: begin
        src_rd_addr = lo;
      end
      ST_REV_B: begin
        src_rd_addr = hi;
      end
      ST_REV_C: begin
        src_wr_en   = 1'b1;
        src_wr_addr = lo;
        src_wr_data = src_rd_data;
      end
      ST_REV_D: begin
        src_wr_en   = 1'b1;
        src_wr_addr = hi;
        src_wr_data = tmp;
      end
      ST_XFER: begin
        src_rd_addr = AW'(sfill - 1'b1);
        dst_wr_en   = pend;
        dst_wr_addr = AW'(dfill);
        dst_wr_data = src_rd_data;
      end
      ST_CMP: begin
        src_rd_addr = AW'(idx);
        dst_rd_addr = AW'(idx);
      end
      default: begin
      end
    endcase
  end

  // Map source and destination onto stacks A and B.
  assign a_wr_en     = cur.stack_sel ? dst_wr_en   : src_wr_en;
  assign a_wr_addr   = cur.stack_sel ? dst_wr_addr : src_wr_addr;
  assign a_wr_data   = cur.stack_sel ? dst_wr_data : src_wr_data;
  assign a_rd_addr   = cur.stack_sel ? dst_rd_addr : src_rd_addr;
  assign b_wr_en     = cur.stack_sel ? src_wr_en   : dst_wr_en;
  assign b_wr_addr   = cur.stack_sel ? src_wr_addr : dst_wr_addr;
  assign b_wr_data   = cur.stack_sel ? src_wr_data : dst_wr_data;
  assign b_rd_addr   = cur.stack_sel ? src_rd_addr : dst_rd_addr;
  assign src_rd_data = cur.stack_sel ? b_rd_data   : a_rd_data;

  dlse_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_store_a (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (a_wr_addr),
    .wr_data (a_wr_data),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  dlse_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_store_b (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (b_wr_data),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  // Sequencer for one request at a time.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cur.req_type)
          OP_POP:      state_next = xfer_rd ? ST_POP : ST_DONE;
          OP_REVERSE:  state_next = (sfill > CW'(1)) ? ST_REV_A : ST_DONE;
          OP_TRANSFER: state_next = (xfer_rd && xfer_fits) ? ST_XFER : ST_DONE;
          OP_COMPARE:  state_next = ST_CMP;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_POP:   state_next = ST_DONE;
      ST_REV_A: state_next = ST_REV_B;
      ST_REV_B: state_next = ST_REV_C;
      ST_REV_C: state_next = ST_REV_D;
      ST_REV_D: begin
        state_next = ((lo + 1'b1) < (hi - 1'b1)) ? ST_REV_A : ST_DONE;
      end
      ST_XFER: begin
        if (!xfer_rd && !pend) begin
          state_next = ST_DONE;
        end
      end
      ST_CMP: begin
        if (!cmp_rd && !pend) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers: state, stack counts, read pipeline flag, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill_a    <= '0;
      fill_b    <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      // The result register refills when a request finishes and empties on a taken beat.
      if ((state == ST_DONE) && res_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          pend <= 1'b0;
        end
        ST_EXEC: begin
          if (cur.req_type == OP_PUSH && sfill < CW'(DEPTH)) begin
            if (cur.stack_sel) begin
              fill_b <= fill_b + 1'b1;
            end else begin
              fill_a <= fill_a + 1'b1;
            end
          end else if (cur.req_type == OP_POP && xfer_rd) begin
            if (cur.stack_sel) begin
              fill_b <= fill_b - 1'b1;
            end else begin
              fill_a <= fill_a - 1'b1;
            end
          end
        end
        ST_XFER: begin
          // Pop from the source as the read issues, push as the word lands.
          if (cur.stack_sel) begin
            fill_b <= fill_b - CW'(xfer_rd);
            fill_a <= fill_a + CW'(pend);
          end else begin
            fill_a <= fill_a - CW'(xfer_rd);
            fill_b <= fill_b + CW'(pend);
          end
          pend <= xfer_rd;
        end
        ST_CMP: begin
          pend <= cmp_rd;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cur <= req;
        end
        status_r <= STAT_OK;
        pop_word <= '0;
        eq_r     <= 1'b0;
        more_r   <= 1'b0;
        idx      <= '0;
      end
      ST_EXEC: begin
        unique case (cur.req_type)
          OP_PUSH: begin
            if (sfill >= CW'(DEPTH)) begin
              status_r <= STAT_FULL;
            end
          end
          OP_POP: begin
            if (!xfer_rd) begin
              status_r <= STAT_EMPTY;
            end
          end
          OP_REVERSE: begin
            lo <= '0;
            hi <= AW'(sfill - 1'b1);
          end
          OP_TRANSFER: begin
            if (!xfer_rd || !xfer_fits) begin
              status_r <= STAT_REFUSED;
            end
          end
          OP_COMPARE: begin
            eq_r   <= (fill_a == fill_b);
            more_r <= (fill_a > fill_b);
          end
          default: begin
          end
        endcase
      end
      ST_POP: begin
        pop_word <= src_rd_data;
      end
      ST_REV_B: begin
        tmp <= src_rd_data;
      end
      ST_REV_D: begin
        lo <= lo + 1'b1;
        hi <= hi - 1'b1;
      end
      ST_CMP: begin
        // Words read in the previous cycle are compared while the next pair is read.
        if (pend && (a_rd_data != b_rd_data)) begin
          eq_r <= 1'b0;
        end
        if (cmp_rd) begin
          idx <= idx + 1'b1;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          res.status        <= status_r;
          res.pop_value     <= DATA_BITS'(pop_word);
          res.sel_empty     <= (sfill == '0);
          res.stacks_equal  <= eq_r;
          res.a_more_than_b <= more_r;
          res.count_a       <= COUNT_BITS'(fill_a);
          res.count_b       <= COUNT_BITS'(fill_b);
        end
      end
      default: begin
      end
    endcase
  end

  `include "dual_lifo_stack_engine_assert.svh"

  // Neither count ever passes the capacity.
  `DLSE_ASSERT_ALWAYS(fill_bound_chk, (fill_a <= CW'(DEPTH)) && (fill_b <= CW'(DEPTH)), "count too high")
  // A request beat always starts the decode step.
  `DLSE_ASSERT_NEXT(accept_exec_chk, req_valid && !req_stall, state == ST_EXEC, "beat not decoded")
  // A transfer step neither loses nor invents an element.
  `DLSE_ASSERT_NEXT(xfer_keep_chk, state == ST_XFER, xfer_total == $past(xfer_total), "count drift")
  // Every swap of a reverse works on two distinct entries in order.
  `DLSE_ASSERT_IMPL(rev_order_chk, state == ST_REV_A, lo < hi, "reverse pointers crossed")
  // A finished request always lands in the result register when it is free.
  `DLSE_ASSERT_NEXT(done_load_chk, (state == ST_DONE) && res_free, res_valid, "result not loaded")

endmodule

[test/dual_lifo_stack_engine_checker.sv]
`timescale 1ns / 100ps

// Watches the request and result channels of the dual stack engine. It keeps its own
// copy of both stacks, works out the result of every accepted request beat, and compares
// each accepted result beat with the oldest prediction still waiting.
module dual_lifo_stack_engine_checker import dlse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        res_valid,
  input  logic        res_stall,
  input  res_t        res,
  output int          fail_count,
  output int          awaited,
  output int unsigned depth_a,
  output int unsigned depth_b
);

  localparam int SLOTS = DEPTH_DEFAULT;

  // Shadow copy of the two stacks; index 0 is stack A, index 1 is stack B.
  bit [DATA_BITS-1:0] words [2][SLOTS];
  int unsigned        fill  [2];
  res_t               pending_results [$];

  initial begin
    fail_count = 0;
    awaited    = 0;
    depth_a    = 0;
    depth_b    = 0;
  end

  // Applies one request to the shadow stacks and returns the result it should produce.
  function automatic res_t apply_request(req_t r);
    res_t               out;
    int unsigned        s;
    int unsigned        d;
    int unsigned        k;
    bit                 same;
    bit [DATA_BITS-1:0] held;
    s   = r.stack_sel;
    d   = 1 - s;
    out = '0;
    out.status = STAT_OK;
    case (r.req_type)
      OP_PUSH: begin
        if (fill[s] >= SLOTS) begin
          out.status = STAT_FULL;
        end else begin
          words[s][fill[s]] = r.push_value;
          fill[s]++;
        end
      end
      OP_POP: begin
        if (fill[s] == 0) begin
          out.status = STAT_EMPTY;
        end else begin
          fill[s]--;
          out.pop_value = words[s][fill[s]];
        end
      end
      OP_REVERSE: begin
        // Swap whole words from both ends toward the middle.
        for (k = 0; k < fill[s] / 2; k++) begin
          held                    = words[s][k];
          words[s][k]             = words[s][fill[s]-1-k];
          words[s][fill[s]-1-k]   = held;
        end
      end
      OP_TRANSFER: begin
        // Refused on an empty source or when the destination cannot take everything.
        if (fill[s] == 0 || fill[s] + fill[d] > SLOTS) begin
          out.status = STAT_REFUSED;
        end else begin
          while (fill[s] > 0) begin
            fill[s]--;
            words[d][fill[d]] = words[s][fill[s]];
            fill[d]++;
          end
        end
      end
      OP_COMPARE: begin
        same = (fill[0] == fill[1]);
        for (k = 0; same && k < fill[0]; k++) begin
          if (words[0][k] != words[1][k]) same = 1'b0;
        end
        out.stacks_equal  = same;
        out.a_more_than_b = (fill[0] > fill[1]);
      end
      default: begin
        // Spare request codes leave the stacks alone.
      end
    endcase
    out.sel_empty = (fill[s] == 0);
    out.count_a   = COUNT_BITS'(fill[0]);
    out.count_b   = COUNT_BITS'(fill[1]);
    return out;
  endfunction

  function automatic void check_field(string name, logic [DATA_BITS-1:0] want,
                                      logic [DATA_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Result beats are matched before the request beat of the same edge is predicted;
  // no result can belong to a request accepted at the same edge.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      fill[0] = 0;
      fill[1] = 0;
      pending_results.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat expected none, got %h", $time, res);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", DATA_BITS'(want.status), DATA_BITS'(res.status));
          check_field("pop_value", want.pop_value, res.pop_value);
          check_field("sel_empty", DATA_BITS'(want.sel_empty), DATA_BITS'(res.sel_empty));
          check_field("stacks_equal", DATA_BITS'(want.stacks_equal),
                      DATA_BITS'(res.stacks_equal));
          check_field("a_more_than_b", DATA_BITS'(want.a_more_than_b),
                      DATA_BITS'(res.a_more_than_b));
          check_field("count_a", DATA_BITS'(want.count_a), DATA_BITS'(res.count_a));
          check_field("count_b", DATA_BITS'(want.count_b), DATA_BITS'(res.count_b));
        end
      end
      if (req_valid && !req_stall) pending_results.push_back(apply_request(req));
    end
    awaited = pending_results.size();
    depth_a = fill[0];
    depth_b = fill[1];
  end

endmodule

[test/dual_lifo_stack_engine_tb.sv]
`timescale 1ns / 100ps

module dual_lifo_stack_engine_tb import dlse_pkg::*; ();

  // Request codes the block does not define; they must still be answered.
  localparam logic [TYPE_BITS-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [TYPE_BITS-1:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_BEATS   = 400;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIRROR, PH_MIXED} phase_t;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        res_valid;
  logic        res_stall;
  res_t        res;
  int          fail_count;
  int          awaited;
  int unsigned depth_a;
  int unsigned depth_b;
  bit          calm;
  int          sent;
  int          idle_cycles;

  dual_lifo_stack_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  dual_lifo_stack_engine_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .fail_count (fail_count),
    .awaited    (awaited),
    .depth_a    (depth_a),
    .depth_b    (depth_b)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Bit patterns from a small pool make equal stacks likely; the rest is random.
  function automatic logic [DATA_BITS-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {(DATA_BITS/2){2'b10}};
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t make_req(logic [TYPE_BITS-1:0] op, logic sel,
                                    logic [DATA_BITS-1:0] w);
    req_t r;
    r.req_type   = op;
    r.stack_sel  = sel;
    r.push_value = w;
    return r;
  endfunction

  function automatic req_t any_req();
    logic [TYPE_BITS-1:0] op;
    case ($urandom_range(0, 9))
      0, 1:    op = OP_PUSH;
      2, 3:    op = OP_POP;
      4:       op = OP_REVERSE;
      5, 6:    op = OP_TRANSFER;
      7, 8:    op = OP_COMPARE;
      default: op = TYPE_BITS'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    endcase
    return make_req(op, 1'($urandom_range(0, 1)), pick_word());
  endfunction

  // Sends one request beat after a random gap and returns at the falling edge after it
  // was accepted. The valid stays high when the next beat follows with no gap.
  task automatic send_beat(req_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!(req_valid && !req_stall));
    @(negedge clk);
    sent++;
  endtask

  // Holds the request channel idle until every predicted result has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
  endtask

  // Result side: stalls a random number of cycles before taking each beat.
  initial begin
    int hold;
    res_stall = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!(res_valid && !res_stall));
      @(negedge clk);
    end
  end

  initial begin
    phase_t phase;
    int     len;
    int     n;
    logic   target;
    logic [DATA_BITS-1:0] w;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    calm      = 1'b0;
    sent      = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty stacks, single element, equal and unequal stacks, both transfer
    // directions, and the spare request codes.
    send_beat(make_req(OP_POP, 1'b0, '0));
    send_beat(make_req(OP_POP, 1'b1, '1));
    send_beat(make_req(OP_COMPARE, 1'b0, '0));
    send_beat(make_req(OP_TRANSFER, 1'b0, '0));
    send_beat(make_req(OP_REVERSE, 1'b0, '0));
    send_beat(make_req(OP_PUSH, 1'b0, '0));
    send_beat(make_req(OP_REVERSE, 1'b0, '0));
    send_beat(make_req(OP_PUSH, 1'b0, '1));
    send_beat(make_req(OP_PUSH, 1'b0, 32'h1234_5678));
    send_beat(make_req(OP_REVERSE, 1'b0, '0));
    send_beat(make_req(OP_PUSH, 1'b1, 32'h1234_5678));
    send_beat(make_req(OP_PUSH, 1'b1, '1));
    send_beat(make_req(OP_PUSH, 1'b1, '0));
    send_beat(make_req(OP_COMPARE, 1'b1, '0));
    send_beat(make_req(OP_PUSH, 1'b1, 32'hA5A5_A5A5));
    send_beat(make_req(OP_COMPARE, 1'b0, '0));
    send_beat(make_req(OP_TRANSFER, 1'b0, '0));
    send_beat(make_req(OP_COMPARE, 1'b0, '0));
    send_beat(make_req(OP_TRANSFER, 1'b1, '0));
    send_beat(make_req(OP_COMPARE, 1'b1, '0));
    send_beat(make_req(OP_POP, 1'b0, '0));
    send_beat(make_req(OP_POP, 1'b1, '0));
    send_beat(make_req(OP_SPARE_LO, 1'b1, '1));
    send_beat(make_req(OP_SPARE_LO + 3'd1, 1'b0, '0));
    send_beat(make_req(OP_SPARE_HI, 1'b1, 32'h5A5A_5A5A));
    drain_results();

    // Random phases. The first one sends mostly pushes to stack A, more beats than it can hold.
    sent   = 0;
    phase  = PH_FILL;
    target = 1'b0;
    len    = 70;
    while (sent < RANDOM_BEATS) begin
      calm = ($urandom_range(0, 3) == 0);
      case (phase)
        PH_FILL: begin
          repeat (len) begin
            if ($urandom_range(0, 9) < 9) send_beat(make_req(OP_PUSH, target, pick_word()));
            else send_beat(any_req());
          end
        end
        PH_DRAIN: begin
          repeat (len) begin
            if ($urandom_range(0, 9) < 8) begin
              send_beat(make_req(OP_POP, 1'($urandom_range(0, 1)), pick_word()));
            end else begin
              send_beat(any_req());
            end
          end
        end
        PH_MIRROR: begin
          // Empty both stacks, build identical contents, then compare them.
          while (depth_a > 0) send_beat(make_req(OP_POP, 1'b0, pick_word()));
          while (depth_b > 0) send_beat(make_req(OP_POP, 1'b1, pick_word()));
          n = $urandom_range(1, 10);
          repeat (n) begin
            w = pick_word();
            send_beat(make_req(OP_PUSH, 1'b0, w));
            send_beat(make_req(OP_PUSH, 1'b1, w));
          end
          if ($urandom_range(0, 1) == 1) begin
            send_beat(make_req(OP_REVERSE, 1'b0, '0));
            send_beat(make_req(OP_REVERSE, 1'b1, '0));
          end
          send_beat(make_req(OP_COMPARE, 1'($urandom_range(0, 1)), pick_word()));
          if ($urandom_range(0, 1) == 1) begin
            send_beat(make_req(OP_PUSH, 1'($urandom_range(0, 1)), pick_word()));
            send_beat(make_req(OP_COMPARE, 1'($urandom_range(0, 1)), pick_word()));
          end
        end
        default: begin
          repeat (len) send_beat(any_req());
        end
      endcase
      if ($urandom_range(0, 9) == 0) drain_results();

      // Pick the next phase.
      case ($urandom_range(0, 9))
        0, 1, 2: phase = PH_FILL;
        3, 4:    phase = PH_DRAIN;
        5, 6:    phase = PH_MIRROR;
        default: phase = PH_MIXED;
      endcase
      target = 1'($urandom_range(0, 1));
      len    = (phase == PH_FILL) ? $urandom_range(20, 70) : $urandom_range(10, 40);
    end

    // Wait for the last results, then give the block time to show any stray beat.
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
